// File: sv/ehkt_pkg.sv
// shared types, constants and the hash step for the hashed key table
// no dependencies; imported by ehkt_front, ehkt_fifo, ehkt_back and the top module
`timescale 1ns / 1ps
`default_nettype none

package ehkt_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam int unsigned ACC_W   = 32;
	localparam int unsigned HASH_W  = 31;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned STAT_W  = 2;

	localparam logic [ACC_W-1:0] TOP_NIBBLE  = 32'hF000_0000;
	localparam int unsigned      NIBBLE_FOLD = 24;
	localparam int unsigned      HASH_SHIFT  = 4;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	// one table operation, as queued between front and back
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [HASH_W-1:0]  key;
		logic [VALUE_W-1:0] value;
	} ehkt_op_t;

	// one elf hash step; a zero byte leaves the hash alone
	function automatic logic [ACC_W-1:0] elf_fold(input logic [ACC_W-1:0] h,
			input logic [7:0] b);
		logic [ACC_W-1:0] t;
		logic [ACC_W-1:0] top;
		t   = (h << HASH_SHIFT) + ACC_W'(b);
		top = t & TOP_NIBBLE;
		t   = (t ^ (top >> NIBBLE_FOLD)) & ~top;
		if (b == 8'd0) begin
			t = h;
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// File: sv/ehkt_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ehkt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/ehkt_front.sv
// front end: accepts name bytes, folds the running hash, queues an operation on the last byte
// depends on ehkt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ehkt_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ehkt_pkg::MODE_W-1:0]   mode,
	input  wire logic [7:0]                    name_char,
	input  wire logic                          last,
	input  wire logic [ehkt_pkg::VALUE_W-1:0]  value,
	input  wire logic                          q_full,
	output logic                               push,
	output ehkt_pkg::ehkt_op_t                 push_op
);

	import ehkt_pkg::*;

	logic [ACC_W-1:0] hash_q;
	logic [ACC_W-1:0] hash_next;
	logic             accept;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign hash_next = elf_fold(hash_q, name_char);
	assign push      = accept && last;

	always_comb begin
		push_op.mode  = mode;
		push_op.key   = hash_next[HASH_W-1:0];
		push_op.value = value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			// restart the hash once the name is complete
			hash_q <= last ? '0 : hash_next;
		end
	end

endmodule

`default_nettype wire

// File: sv/ehkt_fifo.sv
// short request queue between front and back end
// depends on ehkt_pkg
`timescale 1ns / 1ps
`default_nettype none

module ehkt_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ehkt_pkg::ehkt_op_t push_op,
	output logic                    full,
	input  wire logic               pop,
	output ehkt_pkg::ehkt_op_t      head,
	output logic                    empty
);

	import ehkt_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	ehkt_op_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/ehkt_back.sv
// back end: key match, table update and result register
// depends on ehkt_pkg and ehkt_ram
`timescale 1ns / 1ps
`default_nettype none

module ehkt_back #(
	parameter int unsigned CAPACITY   = ehkt_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = ehkt_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ehkt_pkg::ehkt_op_t                 head,
	input  wire logic                               q_empty,
	output logic                                    pop,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ehkt_pkg::STAT_W-1:0]             status,
	output logic [ehkt_pkg::VALUE_W-1:0]            data_out,
	output logic [$clog2(CAPACITY + 1)-1:0]         entry_count,
	output logic [ehkt_pkg::HASH_W-1:0]             name_hash
);

	import ehkt_pkg::*;

	localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_RESULT} state_t;

	state_t              state_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CAPACITY-1:0] hit_q;
	logic [CAPACITY-1:0] free_q;
	logic [HASH_W-1:0]   key_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	ehkt_op_t            op_q;
	logic [STAT_W-1:0]   res_status_q;
	logic                rd_pending_q;

	logic [CAPACITY-1:0]   hit_vec;
	logic [SLOT_W-1:0]     hit_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic                  hit_any;
	logic                  free_any;
	logic                  is_insert;
	logic                  key_we;
	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic                  can_load;

	// parallel key compare against the queue head
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == head.key);
		end
	end

	// lowest matching and lowest free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (free_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign hit_any   = |hit_q;
	assign free_any  = |free_q;
	assign is_insert = (op_q.mode == MODE_INSERT);
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign can_load  = !out_valid || !out_stall;
	assign key_we    = (state_q == ST_DECIDE) && is_insert && !hit_any && free_any;
	assign ram_we    = (state_q == ST_DECIDE) && is_insert && (hit_any || free_any);
	assign ram_waddr = hit_any ? hit_idx : free_idx;

	ehkt_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (DATA_WIDTH'(op_q.value)),
		.raddr (hit_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q[free_idx] <= op_q.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			hit_q        <= '0;
			free_q       <= '0;
			count_q      <= '0;
			op_q         <= '0;
			res_status_q <= STATUS_OK;
			rd_pending_q <= 1'b0;
			out_valid    <= 1'b0;
			status       <= STATUS_OK;
			data_out     <= '0;
			entry_count  <= '0;
			name_hash    <= '0;
		end else begin
			// result taken; in the result state the load below decides instead
			if (out_valid && !out_stall && (state_q != ST_RESULT)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						op_q    <= head;
						hit_q   <= hit_vec;
						free_q  <= ~valid_q;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					res_status_q <= STATUS_OK;
					rd_pending_q <= 1'b0;
					if (is_insert) begin
						if (!hit_any) begin
							if (free_any) begin
								valid_q[free_idx] <= 1'b1;
								count_q           <= count_q + CNT_W'(1);
							end else begin
								res_status_q <= STATUS_FULL;
							end
						end
					end else if (hit_any) begin
						rd_pending_q <= 1'b1;
						if (op_q.mode == MODE_REMOVE) begin
							valid_q[hit_idx] <= 1'b0;
							count_q          <= count_q - CNT_W'(1);
						end
					end else begin
						res_status_q <= STATUS_MISS;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (can_load) begin
						out_valid   <= 1'b1;
						status      <= res_status_q;
						data_out    <= rd_pending_q ? VALUE_W'(ram_rdata) : '0;
						entry_count <= count_q;
						name_hash   <= op_q.key;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/elf_hashed_key_table.sv
// a result shows on out_valid once its key has passed the queue and the back end states
// throughput: name bytes go in one per cycle while in_stall is low; each complete name
// holds the back end through match, update and result before the next name is taken
// reset: arst_n clears the running hash, the queue, all valid bits and the entry count;
// stored keys and values are not cleared and need no clearing pass
// depends on ehkt_pkg, ehkt_front, ehkt_fifo, ehkt_back
`timescale 1ns / 1ps
`default_nettype none

module elf_hashed_key_table #(
	parameter int unsigned CAPACITY   = ehkt_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = ehkt_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// request channel, one name byte per request
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ehkt_pkg::MODE_W-1:0]        mode,
	input  wire logic [7:0]                         name_char,
	input  wire logic                               last,
	input  wire logic [ehkt_pkg::VALUE_W-1:0]       value,
	// result channel, one result per complete name
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ehkt_pkg::STAT_W-1:0]             status,
	output logic [ehkt_pkg::VALUE_W-1:0]            data_out,
	output logic [$clog2(CAPACITY + 1)-1:0]         entry_count,
	output logic [ehkt_pkg::HASH_W-1:0]             name_hash
);

	import ehkt_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// front to queue
	logic     push;
	ehkt_op_t push_op;
	logic     q_full;

	// queue to back
	ehkt_op_t q_head;
	logic     q_empty;
	logic     pop;

	// the front folds each byte into the running hash and, on the last byte,
	// hands the finished 31-bit key with mode and value to the queue
	ehkt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.name_char (name_char),
		.last      (last),
		.value     (value),
		.q_full    (q_full),
		.push      (push),
		.push_op   (push_op)
	);

	// two-deep queue lets bytes keep flowing while the back end is busy
	ehkt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	// the back end matches the key against all valid entries at once, updates
	// the table and holds the result in its output register until taken
	ehkt_back #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_out    (data_out),
		.entry_count (entry_count),
		.name_hash   (name_hash)
	);

	// the entry count never runs past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count above capacity");

	// a full report only ever comes from a full table
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_FULL)) |-> (entry_count == CNT_W'(CAPACITY)))
		else $error("table full reported below capacity");

	// a miss never returns data
	a_miss_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STATUS_MISS)) |-> (data_out == '0))
		else $error("data returned on a miss");

endmodule

`default_nettype wire
